// ===== hdl/gstb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstb_pkg: shared types, codes and lookup functions
// Codes, entry layouts and the talker, system and band maps used by the
// satellite table builder and its cells.
// ----------------------------------------------------------------------------
package gstb_pkg;

	// Default table depth for visible and used satellites.
	localparam int unsigned MAX_SATS_DEF = 32;

	// Stream widths, padded to whole bytes.
	localparam int unsigned IN_TDATA_W  = 64;
	localparam int unsigned OUT_TDATA_W = 56;
	localparam int unsigned COUNT_W     = 6;

	// Command codes carried in s_tuser.
	localparam logic [1:0] CMD_VISIBLE = 2'd0;
	localparam logic [1:0] CMD_USED    = 2'd1;
	localparam logic [1:0] CMD_COMMIT  = 2'd2;

	// Constellation codes.
	localparam logic [7:0] CONST_GPS     = 8'd0;
	localparam logic [7:0] CONST_GALILEO = 8'd2;
	localparam logic [7:0] CONST_BEIDOU  = 8'd3;
	localparam logic [7:0] CONST_QZSS    = 8'd5;
	localparam logic [7:0] CONST_GLONASS = 8'd6;
	localparam logic [7:0] CONST_UNKNOWN = 8'd255;

	// Band codes.
	localparam logic [2:0] BAND_NONE = 3'd0;
	localparam logic [2:0] BAND_L1   = 3'd1;
	localparam logic [2:0] BAND_L2   = 3'd2;
	localparam logic [2:0] BAND_L5   = 3'd5;

	// Position values that mean "not reported".
	localparam logic signed [7:0] ELEV_NONE = -8'sd128;
	localparam logic signed [9:0] AZIM_NONE = -10'sd1;

	// Key used to match visible entries against the used list.
	typedef struct packed {
		logic [7:0] constellation;
		logic [7:0] sat;
	} used_key_t;

	// One visible satellite entry as stored.
	typedef struct packed {
		logic [7:0]        constellation;
		logic [7:0]        sat;
		logic [6:0]        cn0;
		logic [2:0]        band;
		logic signed [7:0] elev;
		logic signed [9:0] azim;
		logic              healthy;
	} vis_entry_t;

	// Contents of one visible cell: the entry and its in-solution flag.
	typedef struct packed {
		vis_entry_t entry;
		logic       used;
	} vis_cell_t;

	// Control broadcast to every visible cell.
	typedef struct packed {
		logic      shift;
		logic      mark;
		used_key_t mark_key;
	} vis_ctrl_t;

	// Input transaction as held for processing.
	typedef struct packed {
		logic [1:0]        cmd;
		logic [7:0]        talker_first;
		logic [7:0]        talker_second;
		logic [7:0]        signal_id;
		logic [7:0]        sat;
		logic signed [7:0] snr;
		logic [6:0]        elevation;
		logic [8:0]        azimuth;
		logic [3:0]        sys_code;
	} item_t;

	// Talker pair to constellation.
	function automatic logic [7:0] talker_to_const(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] c;
		c = CONST_UNKNOWN;
		if (a == "G") begin
			case (b)
				"P": c = CONST_GPS;
				"L": c = CONST_GLONASS;
				"A": c = CONST_GALILEO;
				"B": c = CONST_BEIDOU;
				"Q": c = CONST_QZSS;
				default: c = CONST_UNKNOWN;
			endcase
		end else if (a == "B" && b == "D") begin
			c = CONST_BEIDOU;
		end else if (a == "Q" && b == "Z") begin
			c = CONST_QZSS;
		end
		return c;
	endfunction

	// System id of the used list to constellation.
	function automatic logic [7:0] system_to_const(input logic [3:0] s);
		logic [7:0] c;
		case (s)
			4'd1: c = CONST_GPS;
			4'd2: c = CONST_GLONASS;
			4'd3: c = CONST_GALILEO;
			4'd4: c = CONST_BEIDOU;
			4'd5: c = CONST_QZSS;
			default: c = CONST_UNKNOWN;
		endcase
		return c;
	endfunction

	// Constellation and signal id to band.
	function automatic logic [2:0] band_of(input logic [7:0] c, input logic [7:0] s);
		logic [2:0] b;
		b = BAND_NONE;
		case (c)
			CONST_GPS: begin
				if (s == 8'd0) b = BAND_L1;
				else if (s == 8'd3 || s == 8'd4) b = BAND_L2;
				else if (s == 8'd6 || s == 8'd7) b = BAND_L5;
			end
			CONST_GALILEO: begin
				if (s <= 8'd1) b = BAND_L1;
				else if (s >= 8'd3 && s <= 8'd6) b = BAND_L5;
			end
			CONST_BEIDOU: begin
				if (s <= 8'd1) b = BAND_L1;
				else if (s == 8'd2 || s == 8'd3) b = BAND_L2;
				else if (s == 8'd5 || s == 8'd7) b = BAND_L5;
			end
			CONST_QZSS: begin
				if (s <= 8'd1) b = BAND_L1;
				else if (s == 8'd4 || s == 8'd5) b = BAND_L2;
				else if (s == 8'd8 || s == 8'd9) b = BAND_L5;
			end
			CONST_GLONASS: begin
				if (s == 8'd0) b = BAND_L1;
				else if (s == 8'd2) b = BAND_L2;
			end
			default: b = BAND_NONE;
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/gnss_satellite_table_builder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_satellite_table_builder_top: per-epoch satellite table builder
// Stores visible and used satellites of one epoch in rows of cells and, on
// commit, streams every visible entry with its in-solution flag.
//
// Channel   Dir  Fields
// s_*       in   tuser: command; tdata: talker, signal id, satellite, snr,
//                elevation, azimuth, system id
// m_*       out  tuser: list_unchanged; tlast: last; tdata: entry fields
//
// A visible or used transaction is first captured and then applied to the
// cells. A commit streams each stored visible entry in turn, shifted out of
// cell 0 of the visible chain; an empty epoch yields a single marker
// instead. Output stalls hold the chain and the input channel. Reset clears
// both fill counts and the handshake state; cell contents are not reset.
// ----------------------------------------------------------------------------
module gnss_satellite_table_builder_top #(
	parameter int unsigned MAX_SATS = gstb_pkg::MAX_SATS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] talker_first, [15:8] talker_second, [23:16] signal_id,
	// [31:24] satellite_number, [39:32] snr, [46:40] elevation_in,
	// [55:47] azimuth_in, [59:56] sys_code, [63:60] zero
	input  logic [gstb_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [1:0] command
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] constellation, [15:8] sat_number, [22:16] carrier_to_noise,
	// [25:23] band, [33:26] elevation_out, [43:34] azimuth_out,
	// [44] in_solution, [45] healthy, [51:46] visible_count, [55:52] zero
	output logic [gstb_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [0] list_unchanged
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import gstb_pkg::*;

	localparam int unsigned FILL_W = $clog2(MAX_SATS + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t              state_q;
	item_t               item_q;
	logic [FILL_W-1:0]   vfill_q;
	logic [FILL_W-1:0]   ufill_q;
	logic [FILL_W-1:0]   rem_q;
	logic [FILL_W-1:0]   count_q;

	logic                m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                m_tuser_q;
	logic                m_tlast_q;

	vis_entry_t          new_entry;
	logic                not_reported;
	logic [7:0]          used_const;
	used_key_t           probe_key;
	used_key_t           used_key;
	logic                is_exec;
	logic                vis_ok;
	logic                used_ok;
	logic                out_free;
	logic                load_marker;
	logic                load_entry;
	logic [MAX_SATS-1:0] used_hit;
	vis_ctrl_t           vctrl;
	vis_cell_t           vcell [MAX_SATS];
	vis_cell_t           head;

	// Input is taken only when no item is being processed.
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign is_exec  = (state_q == ST_EXEC);

	// Capture the input transaction.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.cmd           <= s_tuser;
			item_q.talker_first  <= s_tdata[7:0];
			item_q.talker_second <= s_tdata[15:8];
			item_q.signal_id     <= s_tdata[23:16];
			item_q.sat           <= s_tdata[31:24];
			item_q.snr           <= $signed(s_tdata[39:32]);
			item_q.elevation     <= s_tdata[46:40];
			item_q.azimuth       <= s_tdata[55:47];
			item_q.sys_code      <= s_tdata[59:56];
		end
	end

	// Build the visible entry and the used key from the held item.
	always_comb begin
		not_reported            = (item_q.elevation == 7'd0) && (item_q.azimuth == 9'd0);
		new_entry.constellation = talker_to_const(item_q.talker_first, item_q.talker_second);
		new_entry.sat           = item_q.sat;
		new_entry.cn0           = item_q.snr[7] ? 7'd0 : item_q.snr[6:0];
		new_entry.band          = band_of(new_entry.constellation, item_q.signal_id);
		new_entry.elev          = not_reported ? ELEV_NONE : $signed({1'b0, item_q.elevation});
		new_entry.azim          = not_reported ? AZIM_NONE : $signed({1'b0, item_q.azimuth});
		new_entry.healthy       = !item_q.snr[7] && (item_q.snr != 8'sd0);
		used_const              = system_to_const(item_q.sys_code);
		probe_key.constellation = new_entry.constellation;
		probe_key.sat           = item_q.sat;
		used_key.constellation  = used_const;
		used_key.sat            = item_q.sat;
	end

	assign vis_ok = is_exec && (item_q.cmd == CMD_VISIBLE) && (item_q.sat != 8'd0) &&
		(vfill_q < FILL_W'(MAX_SATS));
	assign used_ok = is_exec && (item_q.cmd == CMD_USED) && (item_q.sat != 8'd0) &&
		(used_const != CONST_UNKNOWN) && (ufill_q < FILL_W'(MAX_SATS));

	assign load_marker = is_exec && (item_q.cmd == CMD_COMMIT) &&
		(vfill_q == '0) && out_free;
	assign load_entry  = (state_q == ST_DRAIN) && out_free;

	// Broadcast control for the visible chain.
	always_comb begin
		vctrl.shift    = load_entry;
		vctrl.mark     = used_ok;
		vctrl.mark_key = used_key;
	end

	// Row of used cells, probed with each new visible entry.
	for (genvar j = 0; j < MAX_SATS; j++) begin : g_used
		gstb_used_cell u_cell (
			.clk   (clk),
			.wr_en (used_ok && (ufill_q == FILL_W'(j))),
			.wr_key(used_key),
			.valid (ufill_q > FILL_W'(j)),
			.probe (probe_key),
			.hit   (used_hit[j])
		);
	end

	// Chain of visible cells, shifting toward cell 0 during a commit.
	for (genvar i = 0; i < MAX_SATS; i++) begin : g_vis
		vis_cell_t wr_cell;
		vis_cell_t nb_cell;

		assign wr_cell.entry = new_entry;
		assign wr_cell.used  = |used_hit;

		if (i == MAX_SATS - 1) begin : g_end
			assign nb_cell = vcell[i];
		end else begin : g_mid
			assign nb_cell = vcell[i + 1];
		end

		gstb_vis_cell u_cell (
			.clk    (clk),
			.wr_en  (vis_ok && (vfill_q == FILL_W'(i))),
			.wr_data(wr_cell),
			.ctrl   (vctrl),
			.nb_in  (nb_cell),
			.data   (vcell[i])
		);
	end

	assign head = vcell[0];

	// Sequencer: capture, update, and drain on commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vfill_q <= '0;
			ufill_q <= '0;
			rem_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (item_q.cmd)
						CMD_VISIBLE: begin
							if (vis_ok) vfill_q <= vfill_q + 1'b1;
							state_q <= ST_IDLE;
						end
						CMD_USED: begin
							if (used_ok) ufill_q <= ufill_q + 1'b1;
							state_q <= ST_IDLE;
						end
						CMD_COMMIT: begin
							if (vfill_q == '0) begin
								if (out_free) begin
									ufill_q <= '0;
									state_q <= ST_IDLE;
								end
							end else begin
								rem_q   <= vfill_q;
								count_q <= vfill_q;
								state_q <= ST_DRAIN;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_DRAIN: begin
					if (out_free) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == FILL_W'(1)) begin
							vfill_q <= '0;
							ufill_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_marker || load_entry) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload: a drained entry or the empty-epoch marker.
	always_ff @(posedge clk) begin
		if (load_entry) begin
			m_tdata_q <= {4'd0, COUNT_W'(count_q), head.entry.healthy, head.used,
				head.entry.azim, head.entry.elev, head.entry.band, head.entry.cn0,
				head.entry.sat, head.entry.constellation};
			m_tuser_q <= 1'b0;
			m_tlast_q <= (rem_q == FILL_W'(1));
		end else if (load_marker) begin
			m_tdata_q <= {4'd0, COUNT_W'(0), 1'b0, 1'b0, AZIM_NONE, ELEV_NONE,
				BAND_NONE, 7'd0, 8'd0, CONST_UNKNOWN};
			m_tuser_q <= 1'b1;
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== hdl/gstb_vis_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstb_vis_cell: one cell of the visible satellite chain
// Holds one visible entry and its in-solution flag. The cell is loaded by a
// local write, marks itself when a matching used key is broadcast, and takes
// its neighbor's contents when the chain shifts toward the output.
// ----------------------------------------------------------------------------
module gstb_vis_cell (
	input  logic              clk,
	input  logic              wr_en,
	input  gstb_pkg::vis_cell_t wr_data,
	input  gstb_pkg::vis_ctrl_t ctrl,
	input  gstb_pkg::vis_cell_t nb_in,
	output gstb_pkg::vis_cell_t data
);
	import gstb_pkg::*;

	vis_cell_t cell_q;
	logic      key_hit;

	// Compare the broadcast used key with the stored entry.
	assign key_hit = (cell_q.entry.constellation == ctrl.mark_key.constellation) &&
		(cell_q.entry.sat == ctrl.mark_key.sat);

	// Load, shift or mark the stored entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cell_q <= wr_data;
		end else if (ctrl.shift) begin
			cell_q <= nb_in;
		end else if (ctrl.mark && key_hit) begin
			cell_q.used <= 1'b1;
		end
	end

	assign data = cell_q;

endmodule

// ===== hdl/gstb_used_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstb_used_cell: one cell of the used satellite row
// Holds one (constellation, satellite) key of the used list and reports a
// hit when a probed key equals it and the cell lies below the fill count.
// ----------------------------------------------------------------------------
module gstb_used_cell (
	input  logic                clk,
	input  logic                wr_en,
	input  gstb_pkg::used_key_t wr_key,
	input  logic                valid,
	input  gstb_pkg::used_key_t probe,
	output logic                hit
);
	import gstb_pkg::*;

	used_key_t key_q;

	// Store the key on a write.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q <= wr_key;
		end
	end

	// A cell at or above the fill count never matches.
	assign hit = valid && (key_q == probe);

endmodule

// ===== hdl/gstb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gstb_checker: port-level checks for the satellite table builder
// Watches the output stream for stalled-transaction stability and for
// consistency of the marker and entry fields.
// ----------------------------------------------------------------------------
module gstb_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [gstb_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);
	import gstb_pkg::*;

	// A stalled output transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// The empty-epoch marker always closes its run and reports no entries.
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[51:46] == 6'd0))
		else $error("marker transaction is malformed");

	// A healthy satellite has a nonzero carrier to noise value.
	a_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[45] |-> (m_tdata[22:16] != 7'd0))
		else $error("healthy satellite with zero carrier to noise");

	// Elevation and azimuth are both reported or both missing.
	a_position: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[33:26] == ELEV_NONE) == (m_tdata[43:34] == AZIM_NONE)))
		else $error("elevation and azimuth disagree on reporting");

endmodule

bind gnss_satellite_table_builder_top gstb_checker u_gstb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the satellite table builder
// Feeds visible, used, commit and unknown transactions, first a directed
// set and then random epochs of varied size, with random gaps on the slave
// side and random stalls on the master side. A scoreboard keeps its own copy
// of both tables, predicts every published entry on commit, and compares
// each master-side transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import gstb_pkg::*;

	localparam int unsigned TABLE_DEPTH  = MAX_SATS_DEF;
	localparam logic [1:0]  CMD_IGNORED  = 2'd3;
	localparam int unsigned ITEM_TARGET  = 280;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
	localparam int unsigned REPORT_LIMIT = 10;

	// Master-side tdata layout, lowest field declared last.
	typedef struct packed {
		logic [3:0]        pad;
		logic [5:0]        count;
		logic              healthy;
		logic              in_solution;
		logic signed [9:0] azim;
		logic signed [7:0] elev;
		logic [2:0]        band;
		logic [6:0]        cn0;
		logic [7:0]        sat;
		logic [7:0]        constellation;
	} sky_result_t;

	// One predicted master-side transaction.
	typedef struct {
		sky_result_t data;
		logic        unchanged;
		logic        last;
	} sky_out_t;

	// Tracks both satellite tables and the entries a commit must publish.
	class sky_scoreboard;
		vis_entry_t  sky_list[$];
		used_key_t   used_list[$];
		sky_out_t    pending_entries[$];
		int unsigned mismatches;
		int unsigned strays;

		function logic [7:0] const_of_talker(logic [7:0] a, logic [7:0] b);
			case ({a, b})
				"GP": return CONST_GPS;
				"GL": return CONST_GLONASS;
				"GA": return CONST_GALILEO;
				"GB", "BD": return CONST_BEIDOU;
				"GQ", "QZ": return CONST_QZSS;
				default: return CONST_UNKNOWN;
			endcase
		endfunction

		function logic [7:0] const_of_system(logic [3:0] s);
			case (s)
				4'd1: return CONST_GPS;
				4'd2: return CONST_GLONASS;
				4'd3: return CONST_GALILEO;
				4'd4: return CONST_BEIDOU;
				4'd5: return CONST_QZSS;
				default: return CONST_UNKNOWN;
			endcase
		endfunction

		// Band depends on both the constellation and the signal id.
		function logic [2:0] band_for(logic [7:0] c, logic [7:0] s);
			case (c)
				CONST_GPS: begin
					case (s)
						8'd0: return BAND_L1;
						8'd3, 8'd4: return BAND_L2;
						8'd6, 8'd7: return BAND_L5;
						default: return BAND_NONE;
					endcase
				end
				CONST_GALILEO: begin
					case (s)
						8'd0, 8'd1: return BAND_L1;
						8'd3, 8'd4, 8'd5, 8'd6: return BAND_L5;
						default: return BAND_NONE;
					endcase
				end
				CONST_BEIDOU: begin
					case (s)
						8'd0, 8'd1: return BAND_L1;
						8'd2, 8'd3: return BAND_L2;
						8'd5, 8'd7: return BAND_L5;
						default: return BAND_NONE;
					endcase
				end
				CONST_QZSS: begin
					case (s)
						8'd0, 8'd1: return BAND_L1;
						8'd4, 8'd5: return BAND_L2;
						8'd8, 8'd9: return BAND_L5;
						default: return BAND_NONE;
					endcase
				end
				CONST_GLONASS: begin
					case (s)
						8'd0: return BAND_L1;
						8'd2: return BAND_L2;
						default: return BAND_NONE;
					endcase
				end
				default: return BAND_NONE;
			endcase
		endfunction

		// Updates the tables for one accepted slave-side transaction.
		function void note_item(logic [1:0] cmd, logic [IN_TDATA_W-1:0] data);
			vis_entry_t        e;
			used_key_t         k;
			sky_out_t          r;
			logic signed [7:0] snr;
			logic [6:0]        el;
			logic [8:0]        az;
			logic [7:0]        sat;
			sat = data[31:24];
			snr = data[39:32];
			el  = data[46:40];
			az  = data[55:47];
			case (cmd)
				CMD_VISIBLE: begin
					if (sat != 8'd0 && sky_list.size() < TABLE_DEPTH) begin
						e.constellation = const_of_talker(data[7:0], data[15:8]);
						e.sat = sat;
						e.cn0 = (snr < 0) ? 7'd0 : snr[6:0];
						e.band = band_for(e.constellation, data[23:16]);
						e.healthy = (snr > 0);
						// A zero elevation and azimuth pair means no position.
						if (el == 7'd0 && az == 9'd0) begin
							e.elev = ELEV_NONE;
							e.azim = AZIM_NONE;
						end else begin
							e.elev = {1'b0, el};
							e.azim = {1'b0, az};
						end
						sky_list.push_back(e);
					end
				end
				CMD_USED: begin
					k.constellation = const_of_system(data[59:56]);
					k.sat = sat;
					if (k.constellation != CONST_UNKNOWN && sat != 8'd0 &&
							used_list.size() < TABLE_DEPTH) begin
						used_list.push_back(k);
					end
				end
				CMD_COMMIT: begin
					if (sky_list.size() == 0) begin
						// Empty epoch: a single marker entry.
						r.data = '0;
						r.data.constellation = CONST_UNKNOWN;
						r.data.elev = ELEV_NONE;
						r.data.azim = AZIM_NONE;
						r.unchanged = 1'b1;
						r.last = 1'b1;
						pending_entries.push_back(r);
					end else begin
						foreach (sky_list[i]) begin
							r.data = '0;
							r.data.constellation = sky_list[i].constellation;
							r.data.sat = sky_list[i].sat;
							r.data.cn0 = sky_list[i].cn0;
							r.data.band = sky_list[i].band;
							r.data.elev = sky_list[i].elev;
							r.data.azim = sky_list[i].azim;
							r.data.healthy = sky_list[i].healthy;
							r.data.count = 6'(sky_list.size());
							foreach (used_list[j]) begin
								if (used_list[j].constellation == sky_list[i].constellation &&
										used_list[j].sat == sky_list[i].sat)
									r.data.in_solution = 1'b1;
							end
							r.unchanged = 1'b0;
							r.last = (i == sky_list.size() - 1);
							pending_entries.push_back(r);
						end
					end
					sky_list.delete();
					used_list.delete();
				end
				default: ;
			endcase
		endfunction

		function string describe(sky_result_t d, logic unchanged, logic last);
			return $sformatf({"const=%0d sat=%0d cn0=%0d band=%0d elev=%0d azim=%0d ",
				"used=%0b healthy=%0b count=%0d unchanged=%0b last=%0b pad=%0h"},
				d.constellation, d.sat, d.cn0, d.band, d.elev, d.azim,
				d.in_solution, d.healthy, d.count, unchanged, last, d.pad);
		endfunction

		// Compares one accepted master-side transaction with the oldest prediction.
		function void check_entry(logic [OUT_TDATA_W-1:0] data, logic unchanged, logic last);
			sky_out_t    want;
			sky_result_t got;
			got = data;
			if (pending_entries.size() == 0) begin
				strays++;
				if (strays + mismatches <= REPORT_LIMIT)
					$display("unexpected entry: %s", describe(got, unchanged, last));
				return;
			end
			want = pending_entries.pop_front();
			if (got.constellation !== want.data.constellation ||
					got.sat !== want.data.sat ||
					got.cn0 !== want.data.cn0 ||
					got.band !== want.data.band ||
					got.elev !== want.data.elev ||
					got.azim !== want.data.azim ||
					got.in_solution !== want.data.in_solution ||
					got.healthy !== want.data.healthy ||
					got.count !== want.data.count ||
					got.pad !== want.data.pad ||
					unchanged !== want.unchanged ||
					last !== want.last) begin
				mismatches++;
				if (strays + mismatches <= REPORT_LIMIT) begin
					$display("entry mismatch at %0t", $realtime);
					$display("  expected %s", describe(want.data, want.unchanged, want.last));
					$display("  actual   %s", describe(got, unchanged, last));
				end
			end
		endfunction

		function int unsigned failures();
			return mismatches + strays + pending_entries.size();
		endfunction
	endclass

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [1:0]             s_tuser  = CMD_VISIBLE;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	logic                   calm       = 1'b0;
	int unsigned            items_sent = 0;
	sky_scoreboard          board      = new();

	// Known talker pairs and the system ids that name the same constellation.
	logic [15:0] talkers [7] = '{"GP", "GL", "GA", "GB", "GQ", "BD", "QZ"};
	logic [3:0]  systems [7] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd4, 4'd5};

	gnss_satellite_table_builder_top #(
		.MAX_SATS(TABLE_DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none while the calm flag is set.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_item(logic [15:0] talker, logic [7:0] sig,
			logic [7:0] sat, logic [7:0] snr, logic [6:0] el, logic [8:0] az, logic [3:0] sys);
		return {4'd0, sys, az, el, snr, sat, sig, talker[7:0], talker[15:8]};
	endfunction

	function automatic logic [IN_TDATA_W-1:0] noise_bits();
		return {4'd0, 28'($urandom), 32'($urandom)};
	endfunction

	// Presents one slave-side transaction and waits until it is accepted.
	task automatic send_item(input logic [1:0] cmd, input logic [IN_TDATA_W-1:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do @(posedge clk); while (s_tready !== 1'b1);
		if (cmd == CMD_COMMIT || (cmd != CMD_IGNORED && data[31:24] != 8'd0))
			items_sent++;
	endtask

	// One epoch of visible and used items in random order, closed by a commit.
	task automatic run_epoch(input bit wide);
		int unsigned vis_left;
		int unsigned used_left;
		int unsigned idx;
		int unsigned roll;
		logic [15:0] talker;
		logic [3:0]  sys;
		logic [7:0]  sat;
		logic [7:0]  snr;
		logic [7:0]  sig;
		logic [6:0]  el;
		logic [8:0]  az;
		logic [11:0] seen[$];
		logic [11:0] pick;
		vis_left  = wide ? $urandom_range(28, 36) : $urandom_range(0, 8);
		used_left = wide ? $urandom_range(28, 36) : $urandom_range(0, 6);
		while (vis_left + used_left != 0) begin
			if ($urandom_range(0, 24) == 0)
				send_item(CMD_IGNORED, noise_bits());
			if (vis_left != 0 && (used_left == 0 || $urandom_range(0, 1) == 0)) begin
				idx = $urandom_range(0, 7);
				if (idx < 7) begin
					talker = talkers[idx];
					sys = systems[idx];
				end else begin
					talker = 16'($urandom);
					sys = 4'd0;
				end
				case ($urandom_range(0, 19))
					0: sat = 8'd0;
					1, 2: sat = 8'($urandom);
					default: sat = 8'($urandom_range(1, 16));
				endcase
				case ($urandom_range(0, 9))
					0, 1: snr = 8'hFF;
					2: snr = 8'd0;
					3, 4: snr = 8'($urandom);
					default: snr = 8'($urandom_range(1, 55));
				endcase
				sig = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
				case ($urandom_range(0, 6))
					0: begin
						el = 7'd0;
						az = 9'd0;
					end
					1: begin
						el = 7'($urandom);
						az = 9'($urandom);
					end
					default: begin
						el = 7'($urandom_range(0, 90));
						az = 9'($urandom_range(0, 359));
					end
				endcase
				if (sys != 4'd0 && sat != 8'd0)
					seen.push_back({sys, sat});
				send_item(CMD_VISIBLE, pack_item(talker, sig, sat, snr, el, az, 4'($urandom)));
				vis_left--;
			end else begin
				// Mostly satellites already seen in this epoch, so matches occur.
				roll = $urandom_range(0, 9);
				if (roll < 6 && seen.size() != 0) begin
					pick = seen[$urandom_range(0, seen.size() - 1)];
					sys = pick[11:8];
					sat = pick[7:0];
				end else if (roll < 9) begin
					sys = 4'($urandom_range(1, 5));
					sat = 8'($urandom_range(1, 16));
				end else begin
					sys = 4'($urandom);
					sat = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
				end
				send_item(CMD_USED, pack_item(16'($urandom), 8'($urandom), sat, 8'($urandom),
					7'($urandom), 9'($urandom), sys));
				used_left--;
			end
		end
		send_item(CMD_COMMIT, noise_bits());
	endtask

	// Master side: ready stretches broken by random stalls.
	initial begin
		int unsigned hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			hold = pick_gap();
			if (hold != 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// Observe both channels at each rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid === 1'b1 && s_tready === 1'b1)
				board.note_item(s_tuser, s_tdata);
			if (m_tvalid === 1'b1 && m_tready === 1'b1)
				board.check_entry(m_tdata, m_tuser, m_tlast);
		end
	end

	// Watchdog.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	// Main sequence.
	initial begin
		int unsigned epoch;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Used entry then an empty epoch: marker, and the used list is dropped.
		send_item(CMD_USED, pack_item("GP", 8'd0, 8'd7, 8'd0, 7'd0, 9'd0, 4'd1));
		send_item(CMD_COMMIT, noise_bits());

		// Visible items over every talker, field extremes and position cases.
		send_item(CMD_VISIBLE, pack_item("GP", 8'd0, 8'd7, 8'hFF, 7'd0, 9'd0, 4'd0));
		send_item(CMD_VISIBLE, pack_item("GL", 8'd2, 8'd0, 8'd20, 7'd10, 9'd10, 4'd0));
		send_item(CMD_VISIBLE, pack_item("GL", 8'd2, 8'd255, 8'd127, 7'd127, 9'd511, 4'd15));
		send_item(CMD_VISIBLE, pack_item("GA", 8'd4, 8'd1, 8'd0, 7'd0, 9'd5, 4'd0));
		send_item(CMD_VISIBLE, pack_item("GB", 8'd7, 8'd2, 8'd1, 7'd45, 9'd0, 4'd0));
		send_item(CMD_VISIBLE, pack_item("GQ", 8'd9, 8'd3, 8'h80, 7'd90, 9'd359, 4'd0));
		send_item(CMD_VISIBLE, pack_item("BD", 8'd255, 8'd4, 8'd40, 7'd30, 9'd200, 4'd0));
		send_item(CMD_VISIBLE, pack_item("QZ", 8'd1, 8'd5, 8'd30, 7'd60, 9'd100, 4'd0));
		send_item(CMD_VISIBLE, pack_item("GN", 8'd0, 8'd6, 8'd25, 7'd5, 9'd50, 4'd0));

		// Used items: matches, unknown systems and an empty slot.
		send_item(CMD_USED, pack_item(16'd0, 8'd0, 8'd255, 8'd0, 7'd0, 9'd0, 4'd2));
		send_item(CMD_USED, pack_item(16'd0, 8'd0, 8'd1, 8'd0, 7'd0, 9'd0, 4'd0));
		send_item(CMD_USED, pack_item(16'd0, 8'd0, 8'd2, 8'd0, 7'd0, 9'd0, 4'd15));
		send_item(CMD_USED, pack_item(16'd0, 8'd0, 8'd0, 8'd0, 7'd0, 9'd0, 4'd1));
		send_item(CMD_USED, pack_item(16'd0, 8'd0, 8'd1, 8'd0, 7'd0, 9'd0, 4'd3));
		send_item(CMD_USED, pack_item(16'd0, 8'd0, 8'd4, 8'd0, 7'd0, 9'd0, 4'd4));
		send_item(CMD_USED, pack_item(16'd0, 8'd0, 8'd3, 8'd0, 7'd0, 9'd0, 4'd5));
		send_item(CMD_IGNORED, noise_bits());
		send_item(CMD_COMMIT, noise_bits());

		// Random epochs; an early one and a few others are wide, sized around the table depth.
		epoch = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			run_epoch(epoch == 1 || $urandom_range(0, 11) == 0);
			epoch++;
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (board.pending_entries.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
